// ===== rtl/sop_pkg.sv =====
// Package for the sphere overlap pushback unit.
// Holds field widths, the item payload types and the reset radius.
// No dependencies.
package sop_pkg;

  localparam int unsigned CoordW  = 24;
  localparam int unsigned RadiusW = 23;

  // Default own radius, 0.25 in Q12.12.
  localparam logic [RadiusW-1:0] SelfRadiusReset = 23'd1024;

  typedef struct packed {
    logic signed [CoordW-1:0]  self_x;
    logic signed [CoordW-1:0]  self_y;
    logic signed [CoordW-1:0]  self_z;
    logic signed [CoordW-1:0]  other_x;
    logic signed [CoordW-1:0]  other_y;
    logic signed [CoordW-1:0]  other_z;
    logic        [RadiusW-1:0] other_radius;
  } in_item_t;

  typedef struct packed {
    logic                     hit;
    logic signed [CoordW-1:0] push_x;
    logic signed [CoordW-1:0] push_y;
    logic signed [CoordW-1:0] push_z;
  } out_item_t;

endpackage

// ===== rtl/sphere_overlap_pushback_unit.sv =====
// Top level of the sphere overlap pushback unit: a 54-stage pipeline.
// Depends on sop_pkg for payload types, widths and the reset radius.
//
// Channel  Direction  Handshake                    Payload
// in       input      in_valid_i / in_stall_o      sop_pkg::in_item_t
// out      output     out_valid_o / out_stall_i    sop_pkg::out_item_t
// cfg      input      cfg_we_i                     cfg_wdata_i (self radius)
//
// One item enters per cycle unless the output stalls; each result passes
// the 24-stage square root and the 24-stage divider, one bit a stage.
// Reset clears every stage valid bit and loads the radius with 0.25.
// A stalled result freezes the whole pipeline, so the input stalls with it;
// empty stages keep no item and nothing is dropped or repeated.
module sphere_overlap_pushback_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sop_pkg::RadiusW-1:0]      cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  sop_pkg::in_item_t                in_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output sop_pkg::out_item_t               out_o
);

  localparam int unsigned Steps = 24;

  typedef struct packed {
    logic        hit;
    logic        zero;
    logic [2:0]  sgn;
    logic [2:0][23:0] mag;
    logic [23:0] rad_sum;
    logic [47:0] rad;
    logic [26:0] rem;
    logic [23:0] root;
  } sqrt_t;

  typedef struct packed {
    logic        hit;
    logic        zero;
    logic [2:0]  sgn;
    logic [23:0] divisor;
    logic [2:0][24:0] rem;
    logic [2:0][23:0] low;
    logic [2:0][23:0] quo;
  } div_t;

  // One square root step: two radicand bits in, one root bit out.
  function automatic sqrt_t sqrt_step(sqrt_t a);
    sqrt_t       b;
    logic [26:0] t;
    logic [26:0] trial;
    b     = a;
    t     = {a.rem[24:0], a.rad[47:46]};
    trial = {1'b0, a.root, 2'b01};
    b.rad = {a.rad[45:0], 2'b00};
    if (t >= trial) begin
      b.rem  = t - trial;
      b.root = {a.root[22:0], 1'b1};
    end else begin
      b.rem  = t;
      b.root = {a.root[22:0], 1'b0};
    end
    return b;
  endfunction

  // One restoring division step on all three components.
  function automatic div_t div_step(div_t a);
    div_t        b;
    logic [25:0] t;
    b = a;
    for (int i = 0; i < 3; i++) begin
      t = {a.rem[i], a.low[i][23]};
      b.low[i] = {a.low[i][22:0], 1'b0};
      if (t >= {2'b00, a.divisor}) begin
        t = t - {2'b00, a.divisor};
        b.quo[i] = {a.quo[i][22:0], 1'b1};
      end else begin
        b.quo[i] = {a.quo[i][22:0], 1'b0};
      end
      b.rem[i] = t[24:0];
    end
    return b;
  endfunction

  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // Configuration register.
  logic [sop_pkg::RadiusW-1:0] self_radius_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_radius_q <= sop_pkg::SelfRadiusReset;
    end else if (cfg_we_i) begin
      self_radius_q <= cfg_wdata_i;
    end
  end

  // Stage 1: difference vector, magnitudes and radius sum.
  logic             v1_q;
  logic [2:0]       sgn1_q;
  logic [2:0][23:0] mag1_q;
  logic [23:0]      rs1_q;
  logic [2:0][24:0] diff;
  always_comb begin
    diff[0] = {in_i.other_x[23], in_i.other_x} - {in_i.self_x[23], in_i.self_x};
    diff[1] = {in_i.other_y[23], in_i.other_y} - {in_i.self_y[23], in_i.self_y};
    diff[2] = {in_i.other_z[23], in_i.other_z} - {in_i.self_z[23], in_i.self_z};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sgn1_q[i] <= diff[i][24];
        mag1_q[i] <= diff[i][24] ? 24'(-diff[i]) : diff[i][23:0];
      end
      rs1_q <= {1'b0, self_radius_q} + {1'b0, in_i.other_radius};
    end
  end

  // Stage 2: squares of the components and of the radius sum.
  logic             v2_q;
  logic [2:0]       sgn2_q;
  logic [2:0][23:0] mag2_q;
  logic [23:0]      rs2_q;
  logic [2:0][47:0] sq2_q;
  logic [47:0]      rsq2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq2_q[i] <= 48'(mag1_q[i]) * 48'(mag1_q[i]);
      end
      rsq2_q <= 48'(rs1_q) * 48'(rs1_q);
      sgn2_q <= sgn1_q;
      mag2_q <= mag1_q;
      rs2_q  <= rs1_q;
    end
  end

  // Stage 3: squared distance, hit test and square root setup.
  logic        v3_q;
  sqrt_t       s3_q;
  logic [49:0] dist2;
  assign dist2 = 50'(sq2_q[0]) + 50'(sq2_q[1]) + 50'(sq2_q[2]);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_q.hit     <= dist2 <= {2'b00, rsq2_q};
      s3_q.zero    <= dist2 == '0;
      s3_q.sgn     <= sgn2_q;
      s3_q.mag     <= mag2_q;
      s3_q.rad_sum <= rs2_q;
      s3_q.rad     <= dist2[47:0];
      s3_q.rem     <= '0;
      s3_q.root    <= '0;
    end
  end

  // Square root stages, one root bit each.
  logic  [Steps-1:0] vs_q;
  sqrt_t [Steps-1:0] sq_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q[0] <= sqrt_step(s3_q);
      for (int k = 1; k < Steps; k++) begin
        sq_q[k] <= sqrt_step(sq_q[k-1]);
      end
    end
  end

  // Overlap products stage.
  logic             vm_q;
  logic             hitm_q;
  logic             zerom_q;
  logic [2:0]       sgnm_q;
  logic [23:0]      distm_q;
  logic [2:0][47:0] prodm_q;
  logic [23:0]      overlap;
  assign overlap = sq_q[Steps-1].rad_sum - sq_q[Steps-1].root;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        prodm_q[i] <= 48'(sq_q[Steps-1].mag[i]) * 48'(overlap);
      end
      hitm_q  <= sq_q[Steps-1].hit;
      zerom_q <= sq_q[Steps-1].zero;
      sgnm_q  <= sq_q[Steps-1].sgn;
      distm_q <= sq_q[Steps-1].root;
    end
  end

  // Division setup: add half the divisor for rounding, split the numerator.
  logic             vn_q;
  div_t             dn_q;
  logic [2:0][48:0] num;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = {1'b0, prodm_q[i]} + 49'(distm_q[23:1]);
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dn_q.hit     <= hitm_q;
      dn_q.zero    <= zerom_q;
      dn_q.sgn     <= sgnm_q;
      dn_q.divisor <= distm_q;
      for (int i = 0; i < 3; i++) begin
        dn_q.rem[i] <= num[i][48:24];
        dn_q.low[i] <= num[i][23:0];
      end
      dn_q.quo <= '0;
    end
  end

  // Division stages, one quotient bit each.
  logic [Steps-1:0] vd_q;
  div_t [Steps-1:0] dv_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q[0] <= div_step(dn_q);
      for (int k = 1; k < Steps; k++) begin
        dv_q[k] <= div_step(dv_q[k-1]);
      end
    end
  end

  // Output stage: sign, saturation and masking of misses and zero distances.
  logic             vo_q;
  sop_pkg::out_item_t out_q;
  logic [2:0][23:0] push;
  div_t             dl;
  assign dl = dv_q[Steps-1];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!dl.hit || dl.zero) begin
        push[i] = '0;
      end else if (dl.sgn[i]) begin
        push[i] = (dl.quo[i] > 24'h800000) ? 24'h800000 : 24'(-dl.quo[i]);
      end else begin
        push[i] = (dl.quo[i] > 24'h7FFFFF) ? 24'h7FFFFF : dl.quo[i];
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.hit    <= dl.hit;
      out_q.push_x <= push[0];
      out_q.push_y <= push[1];
      out_q.push_z <= push[2];
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vs_q <= '0;
      vm_q <= 1'b0;
      vn_q <= 1'b0;
      vd_q <= '0;
      vo_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vs_q <= {vs_q[Steps-2:0], v3_q};
      vm_q <= vs_q[Steps-1];
      vn_q <= vm_q;
      vd_q <= {vd_q[Steps-2:0], vn_q};
      vo_q <= vd_q[Steps-1];
    end
  end

  assign out_valid_o = vo_q;
  assign out_o       = out_q;

`ifndef SYNTHESIS
  // A miss never carries a push vector.
  a_miss_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.hit |-> out_o.push_x == '0 && out_o.push_y == '0 &&
    out_o.push_z == '0)
    else $error("push vector nonzero on a miss");

  // A stalled result must hold the input off.
  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input accepted while result stalled");

  // The result register holds while stalled.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed");
`endif

endmodule
